// ===== rtl/core/lzwe_pkg.sv =====
// lzwe_pkg: types and constants shared by the LZW image encoder core.
// No dependencies.
package lzwe_pkg;

    localparam int unsigned ROOT_BITS_MIN = 2;
    localparam int unsigned ROOT_BITS_MAX = 8;
    localparam int unsigned ROOT_CNT_MAX  = 256;

    localparam logic [1:0] CFG_MIN_CODE_BITS = 2'd0;
    localparam logic [1:0] CFG_EARLY_CHANGE  = 2'd1;
    localparam logic [1:0] CFG_MSB_FIRST     = 2'd2;

    localparam logic OP_PIXEL  = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_OP      = 11'b000_0000_0010,
        S_FC_WAIT = 11'b000_0000_0100,
        S_FC_CHK  = 11'b000_0000_1000,
        S_SB_WAIT = 11'b000_0001_0000,
        S_SB_CHK  = 11'b000_0010_0000,
        S_MISS    = 11'b000_0100_0000,
        S_WR2     = 11'b000_1000_0000,
        S_SEND    = 11'b001_0000_0000,
        S_EMIT    = 11'b010_0000_0000,
        S_FLUSH   = 11'b100_0000_0000
    } t_state;

    // what follows once the bytes of a code are out
    typedef enum logic [5:0] {
        ST_START_CLR = 6'b00_0001,
        ST_CUR       = 6'b00_0010,
        ST_FULL_CUR  = 6'b00_0100,
        ST_FULL_CLR  = 6'b00_1000,
        ST_FIN_CUR   = 6'b01_0000,
        ST_END       = 6'b10_0000
    } t_step;

endpackage

// ===== rtl/core/lzw_image_encoder_core.sv =====
// lzw_image_encoder_core: LZW encoder with byte packer; depends on lzwe_pkg.
// One item at a time, ready again once back in S_IDLE: a pixel that hits walks child
// nodes; a miss also writes the entry and sends the current code (plus a clear code on
// a full table); a finish sends any current code, the end code and a flush byte if bits
// remain. A stream's first item sends the clear code first; a full output reg stalls.
// Reset is synchronous; root first-child links are cleared through valid bits, no sweep.
module lzw_image_encoder_core #(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_opcode,
    input  logic [7:0] i_symbol,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_stream_end
);

    localparam int CW    = MAX_CODE_BITS;
    localparam int DEPTH = 1 << MAX_CODE_BITS;
    localparam int ACC_W = MAX_CODE_BITS + 8;
    localparam int SB_W  = MAX_CODE_BITS + 8;

    // config
    logic [3:0] r_min_bits;
    logic       r_early;
    logic       r_msb;

    // state
    lzwe_pkg::t_state r_state;
    lzwe_pkg::t_step  r_step;
    logic [3:0]       r_root;
    logic [CW-1:0]    r_cur;
    logic             r_cur_vld;
    logic [CW:0]      r_nfc;
    logic [3:0]       r_width;
    logic [ACC_W-1:0] r_acc;
    logic [4:0]       r_cnt;
    logic             r_open;
    logic             r_op;
    logic [7:0]       r_sym;
    logic [CW-1:0]    r_code;
    logic             r_final;
    logic [CW-1:0]    r_head;
    logic [CW-1:0]    r_lno;
    logic [lzwe_pkg::ROOT_CNT_MAX-1:0] r_root_vld;

    // output register
    logic       r_ovld;
    logic [7:0] r_obyte;
    logic       r_olast;
    logic       r_oend;

    // dictionary
    logic [CW-1:0]   fc_mem [DEPTH];
    logic [SB_W-1:0] sb_mem [DEPTH];
    logic [CW-1:0]   r_fc_q;
    logic [SB_W-1:0] r_sb_q;

    logic [3:0]    n_root_clamp;
    logic [3:0]    sel_root;
    logic [8:0]    roots;
    logic [8:0]    sel_roots;
    logic [7:0]    sym_mask;
    logic          cur_is_root;
    logic [CW-1:0] head;
    logic [CW-1:0] sb_next;
    logic [7:0]    sb_sym;
    logic [CW-1:0] code_m;
    logic [CW:0]   wmask;
    logic [ACC_W-1:0] send_acc;
    logic [4:0]    cnt_after;
    logic [ACC_W-1:0] msb_shift;
    logic [ACC_W-1:0] rem_mask;
    logic [7:0]    emit_byte;
    logic [7:0]    flush_byte;
    logic          emit_last;
    logic          can_push;
    logic          push_now;
    logic [CW+1:0] nfc_inc_e;
    logic [CW+1:0] width_pow;

    always_comb begin
        if (r_min_bits < 4'(lzwe_pkg::ROOT_BITS_MIN)) begin
            n_root_clamp = 4'(lzwe_pkg::ROOT_BITS_MIN);
        end else if (r_min_bits > 4'(lzwe_pkg::ROOT_BITS_MAX)) begin
            n_root_clamp = 4'(lzwe_pkg::ROOT_BITS_MAX);
        end else begin
            n_root_clamp = r_min_bits;
        end
    end

    assign sel_root    = r_open ? r_root : n_root_clamp;
    assign roots       = 9'd1 << r_root;
    assign sel_roots   = 9'd1 << sel_root;
    assign sym_mask    = 8'(sel_roots - 9'd1);
    assign cur_is_root = r_cur < CW'(roots);
    assign head        = (cur_is_root && !r_root_vld[r_cur[7:0]]) ? '0 : r_fc_q;
    assign sb_next     = r_sb_q[SB_W-1:8];
    assign sb_sym      = r_sb_q[7:0];

    assign wmask  = ((CW+1)'(1) << r_width) - (CW+1)'(1);
    assign code_m = r_code & wmask[CW-1:0];

    always_comb begin
        if (r_msb) begin
            send_acc = (r_acc << r_width) | ACC_W'(code_m);
        end else begin
            send_acc = r_acc | (ACC_W'(code_m) << r_cnt);
        end
    end

    assign cnt_after = r_cnt - 5'd8;
    assign msb_shift = r_acc >> cnt_after;
    assign rem_mask  = (ACC_W'(1) << cnt_after) - ACC_W'(1);
    assign emit_byte = r_msb ? msb_shift[7:0] : r_acc[7:0];
    assign flush_byte = r_msb ? 8'(r_acc[7:0] << (5'd8 - r_cnt)) : r_acc[7:0];
    assign emit_last = r_final && (cnt_after < 5'd8) &&
                       !(r_step == lzwe_pkg::ST_END && cnt_after != 5'd0);
    assign can_push  = !r_ovld || i_out_ready;
    assign push_now  = can_push && ((r_state == lzwe_pkg::S_EMIT && r_cnt >= 5'd8) ||
                                    r_state == lzwe_pkg::S_FLUSH);

    assign nfc_inc_e = (CW+2)'(r_nfc) + (CW+2)'(1) + (CW+2)'(r_early);
    assign width_pow = (CW+2)'(1) << r_width;

    // dictionary memories
    always_ff @(posedge i_clk) begin
        if (r_state == lzwe_pkg::S_MISS && !r_nfc[CW]) begin
            fc_mem[r_nfc[CW-1:0]] <= '0;
        end else if (r_state == lzwe_pkg::S_WR2) begin
            fc_mem[r_cur] <= r_nfc[CW-1:0];
        end
        r_fc_q <= fc_mem[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lzwe_pkg::S_MISS && !r_nfc[CW]) begin
            sb_mem[r_nfc[CW-1:0]] <= {r_head, r_sym};
        end
        r_sb_q <= sb_mem[r_lno];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bits <= 4'd8;
            r_early    <= 1'b0;
            r_msb      <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                lzwe_pkg::CFG_MIN_CODE_BITS: r_min_bits <= i_cfg_data;
                lzwe_pkg::CFG_EARLY_CHANGE:  r_early    <= i_cfg_data[0];
                lzwe_pkg::CFG_MSB_FIRST:     r_msb      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lzwe_pkg::S_IDLE;
            r_step     <= lzwe_pkg::ST_START_CLR;
            r_root     <= 4'd8;
            r_cur      <= '0;
            r_cur_vld  <= 1'b0;
            r_nfc      <= (CW+1)'(258);
            r_width    <= 4'd9;
            r_acc      <= '0;
            r_cnt      <= '0;
            r_open     <= 1'b0;
            r_op       <= 1'b0;
            r_final    <= 1'b0;
            r_root_vld <= '0;
            r_ovld     <= 1'b0;
        end else begin
            if (r_ovld && i_out_ready && !push_now) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                lzwe_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        r_op  <= i_opcode;
                        r_sym <= i_symbol & sym_mask;
                        if (!r_open) begin
                            r_root     <= n_root_clamp;
                            r_root_vld <= '0;
                            r_nfc      <= (CW+1)'(sel_roots) + (CW+1)'(2);
                            r_width    <= n_root_clamp + 4'd1;
                            r_cur_vld  <= 1'b0;
                            r_cur      <= '0;
                            r_acc      <= '0;
                            r_cnt      <= '0;
                            r_open     <= 1'b1;
                            r_code     <= CW'(sel_roots);
                            r_step     <= lzwe_pkg::ST_START_CLR;
                            r_final    <= (i_opcode == lzwe_pkg::OP_PIXEL);
                            r_state    <= lzwe_pkg::S_SEND;
                        end else begin
                            r_state <= lzwe_pkg::S_OP;
                        end
                    end
                end
                lzwe_pkg::S_OP: begin
                    if (r_op == lzwe_pkg::OP_PIXEL) begin
                        if (!r_cur_vld) begin
                            r_cur     <= CW'(r_sym);
                            r_cur_vld <= 1'b1;
                            r_state   <= lzwe_pkg::S_IDLE;
                        end else begin
                            r_state <= lzwe_pkg::S_FC_WAIT;
                        end
                    end else if (r_cur_vld) begin
                        r_code  <= r_cur;
                        r_step  <= lzwe_pkg::ST_FIN_CUR;
                        r_final <= 1'b0;
                        r_state <= lzwe_pkg::S_SEND;
                    end else begin
                        r_code  <= CW'(roots) + CW'(1);
                        r_step  <= lzwe_pkg::ST_END;
                        r_final <= 1'b1;
                        r_state <= lzwe_pkg::S_SEND;
                    end
                end
                lzwe_pkg::S_FC_WAIT: r_state <= lzwe_pkg::S_FC_CHK;
                lzwe_pkg::S_FC_CHK: begin
                    r_head <= head;
                    r_lno  <= head;
                    r_state <= (head == '0) ? lzwe_pkg::S_MISS : lzwe_pkg::S_SB_WAIT;
                end
                lzwe_pkg::S_SB_WAIT: r_state <= lzwe_pkg::S_SB_CHK;
                lzwe_pkg::S_SB_CHK: begin
                    if (sb_sym == r_sym && (CW+1)'(r_lno) != r_nfc - (CW+1)'(1)) begin
                        r_cur   <= r_lno;
                        r_state <= lzwe_pkg::S_IDLE;
                    end else begin
                        r_lno   <= sb_next;
                        r_state <= (sb_next == '0) ? lzwe_pkg::S_MISS : lzwe_pkg::S_SB_WAIT;
                    end
                end
                lzwe_pkg::S_MISS: begin
                    r_code <= r_cur;
                    if (r_nfc[CW]) begin
                        // table full: current code, then clear code
                        r_step  <= lzwe_pkg::ST_FULL_CUR;
                        r_final <= 1'b0;
                        r_state <= lzwe_pkg::S_SEND;
                    end else begin
                        r_state <= lzwe_pkg::S_WR2;
                    end
                end
                lzwe_pkg::S_WR2: begin
                    if (cur_is_root) begin
                        r_root_vld[r_cur[7:0]] <= 1'b1;
                    end
                    r_step  <= lzwe_pkg::ST_CUR;
                    r_final <= 1'b1;
                    r_state <= lzwe_pkg::S_SEND;
                end
                lzwe_pkg::S_SEND: begin
                    r_acc   <= send_acc;
                    r_cnt   <= r_cnt + 5'(r_width);
                    r_state <= lzwe_pkg::S_EMIT;
                end
                lzwe_pkg::S_EMIT: begin
                    if (r_cnt >= 5'd8) begin
                        if (can_push) begin
                            r_ovld  <= 1'b1;
                            r_obyte <= emit_byte;
                            r_olast <= emit_last;
                            r_oend  <= emit_last && r_op;
                            r_cnt   <= cnt_after;
                            r_acc   <= r_msb ? (r_acc & rem_mask) : (r_acc >> 8);
                        end
                    end else begin
                        case (r_step)
                            lzwe_pkg::ST_START_CLR: r_state <= lzwe_pkg::S_OP;
                            lzwe_pkg::ST_CUR: begin
                                r_cur <= CW'(r_sym);
                                r_nfc <= r_nfc + (CW+1)'(1);
                                if (r_width < 4'(MAX_CODE_BITS) && nfc_inc_e > width_pow) begin
                                    r_width <= r_width + 4'd1;
                                end
                                r_state <= lzwe_pkg::S_IDLE;
                            end
                            lzwe_pkg::ST_FULL_CUR: begin
                                r_code  <= CW'(roots);
                                r_step  <= lzwe_pkg::ST_FULL_CLR;
                                r_final <= 1'b1;
                                r_state <= lzwe_pkg::S_SEND;
                            end
                            lzwe_pkg::ST_FULL_CLR: begin
                                r_root_vld <= '0;
                                r_nfc      <= (CW+1)'(roots) + (CW+1)'(2);
                                r_width    <= r_root + 4'd1;
                                r_cur      <= CW'(r_sym);
                                r_state    <= lzwe_pkg::S_IDLE;
                            end
                            lzwe_pkg::ST_FIN_CUR: begin
                                r_code  <= CW'(roots) + CW'(1);
                                r_step  <= lzwe_pkg::ST_END;
                                r_final <= 1'b1;
                                r_state <= lzwe_pkg::S_SEND;
                            end
                            lzwe_pkg::ST_END: begin
                                if (r_cnt != 5'd0) begin
                                    r_state <= lzwe_pkg::S_FLUSH;
                                end else begin
                                    r_acc     <= '0;
                                    r_cur_vld <= 1'b0;
                                    r_cur     <= '0;
                                    r_open    <= 1'b0;
                                    r_state   <= lzwe_pkg::S_IDLE;
                                end
                            end
                            default: r_state <= lzwe_pkg::S_IDLE;
                        endcase
                    end
                end
                lzwe_pkg::S_FLUSH: begin
                    if (can_push) begin
                        r_ovld    <= 1'b1;
                        r_obyte   <= flush_byte;
                        r_olast   <= 1'b1;
                        r_oend    <= 1'b1;
                        r_acc     <= '0;
                        r_cnt     <= '0;
                        r_cur_vld <= 1'b0;
                        r_cur     <= '0;
                        r_open    <= 1'b0;
                        r_state   <= lzwe_pkg::S_IDLE;
                    end
                end
                default: r_state <= lzwe_pkg::S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == lzwe_pkg::S_IDLE);
    assign o_out_valid  = r_ovld;
    assign o_out_byte   = r_obyte;
    assign o_run_last   = r_olast;
    assign o_stream_end = r_oend;

endmodule
